// File: hw/rtl/mecq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element quality checker package
// Shared widths, codes and transfer types for the element checker blocks.
// ----------------------------------------------------------------------------
package mecq_pkg;

    // Node store and coordinates
    localparam int NODE_COUNT     = 4096;
    localparam int NODE_AW        = 12;
    localparam int COORD_BITS     = 24;
    localparam int DIFF_W         = COORD_BITS + 1;
    localparam int MUL_W          = DIFF_W + 1;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int HALF_W         = DIFF_W;
    localparam int NORM_W         = 2 * HALF_W;
    localparam int CROSS_W        = NORM_W + 1;
    localparam int P_W            = 2 * NORM_W;

    // Corner sine
    localparam int SINE_FRAC_BITS = 15;
    localparam int U_W            = SINE_FRAC_BITS + 1;
    localparam int BIT_W          = $clog2(U_W);
    localparam int SQ_W           = 2 * NORM_W + 2 * SINE_FRAC_BITS + 2;
    localparam int J_W            = SINE_FRAC_BITS + 3;
    localparam int JSUM_W         = J_W + 2;

    // Results and accumulators
    localparam int AREA_W         = 52;
    localparam int SUM_W          = 64;
    localparam int CNT_W          = 21;
    localparam int MAX_ELEMENTS   = 1048576;
    localparam int LIMIT_W        = 16;

    // Queue between front and back
    localparam int Q_DEPTH        = 2;
    localparam int Q_PW           = 1;

    // Operations
    localparam logic [1:0] OP_WRITE_NODE = 2'd0;
    localparam logic [1:0] OP_TRIANGLE   = 2'd1;
    localparam logic [1:0] OP_QUAD       = 2'd2;
    localparam logic [1:0] OP_FINISH     = 2'd3;

    // Area status
    localparam logic [1:0] ST_POSITIVE    = 2'd0;
    localparam logic [1:0] ST_NEGATIVE    = 2'd1;
    localparam logic [1:0] ST_ZERO        = 2'd2;
    localparam logic [1:0] ST_NOT_ELEMENT = 2'd3;

    // Quad class
    localparam logic [1:0] CL_NEGATIVE        = 2'd0;
    localparam logic [1:0] CL_NEGATIVE_SKEWED = 2'd1;
    localparam logic [1:0] CL_POSITIVE_SKEWED = 2'd2;
    localparam logic [1:0] CL_POSITIVE        = 2'd3;

    // Verdict
    localparam logic [1:0] VD_VALID        = 2'd0;
    localparam logic [1:0] VD_ALL_NEGATIVE = 2'd1;
    localparam logic [1:0] VD_MIXED        = 2'd2;
    localparam logic [1:0] VD_ZERO_AREA    = 2'd3;

    // Register map
    localparam logic [1:0] REG_ZERO_AREA_LIMIT = 2'd0;

    typedef struct packed {
        logic [1:0]                   operation;
        logic [NODE_AW-1:0]           node_index;
        logic signed [COORD_BITS-1:0] node_x;
        logic signed [COORD_BITS-1:0] node_y;
        logic [NODE_AW-1:0]           corner_a;
        logic [NODE_AW-1:0]           corner_b;
        logic [NODE_AW-1:0]           corner_c;
        logic [NODE_AW-1:0]           corner_d;
    } mecq_item_t;

    typedef struct packed {
        logic signed [AREA_W-1:0] area_twice;
        logic [1:0]               area_status;
        logic [1:0]               quad_class;
        logic signed [SUM_W-1:0]  total_area_twice;
        logic [CNT_W-1:0]         negative_triangles;
        logic [CNT_W-1:0]         negative_quads;
        logic [CNT_W-1:0]         quads_negative;
        logic [CNT_W-1:0]         quads_negative_skewed;
        logic [CNT_W-1:0]         quads_positive_skewed;
        logic [CNT_W-1:0]         quads_positive;
        logic [1:0]               verdict;
    } mecq_result_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } mecq_point_t;

    typedef struct packed {
        logic [1:0]        operation;
        mecq_point_t [3:0] pt;
    } mecq_entry_t;

endpackage

// File: hw/rtl/mecq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element checker front end
// Accepts items, owns the node store and gathers corner coordinates.
// ----------------------------------------------------------------------------
module mecq_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  mecq_pkg::mecq_item_t  item,
    output logic                  push,
    output mecq_pkg::mecq_entry_t push_entry,
    input  logic                  q_full
);
    import mecq_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_READ, F_PUSH} fstate_t;

    fstate_t                     state_reg;
    logic [2:0]                  cnt_reg;
    logic [1:0]                  op_reg;
    logic [3:0][NODE_AW-1:0]     corner_reg;
    mecq_point_t [3:0]           pt_reg;
    logic [2*COORD_BITS-1:0]     node_mem [NODE_COUNT];
    logic [2*COORD_BITS-1:0]     rd_data_reg;

    logic       accept;
    logic       wr_en;
    logic       rd_en;
    logic [1:0] fill_idx;
    logic       direct_op;

    assign item_ready = (state_reg == F_IDLE) && !q_full;
    assign accept     = item_valid && item_ready;
    assign direct_op  = (item.operation == OP_WRITE_NODE) || (item.operation == OP_FINISH);
    assign wr_en      = accept && (item.operation == OP_WRITE_NODE);
    assign rd_en      = (state_reg == F_READ) && !cnt_reg[2];
    assign fill_idx   = cnt_reg[1:0] - 2'd1;

    // Push write and finish items at once, elements after their corners arrive
    always_comb
    begin
        push_entry = '0;
        if (state_reg == F_IDLE)
        begin
            push             = accept && direct_op;
            push_entry.operation = item.operation;
        end
        else
        begin
            push             = (state_reg == F_PUSH) && !q_full;
            push_entry.operation = op_reg;
            push_entry.pt        = pt_reg;
        end
    end

    // Node store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[item.node_index] <= {item.node_x, item.node_y};
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[corner_reg[cnt_reg[1:0]]];
        end
    end

    // Sequence corner reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            op_reg     <= '0;
            corner_reg <= '0;
            pt_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept && !direct_op)
                    begin
                        op_reg     <= item.operation;
                        corner_reg <= {item.corner_d, item.corner_c,
                                       item.corner_b, item.corner_a};
                        cnt_reg    <= '0;
                        state_reg  <= F_READ;
                    end
                end
                F_READ:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0)
                    begin
                        pt_reg[fill_idx] <= mecq_point_t'(rd_data_reg);
                    end
                    if (cnt_reg[2])
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mecq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element checker queue
// Short FIFO of gathered elements and of write and finish items between the front and back ends.
// ----------------------------------------------------------------------------
module mecq_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mecq_pkg::mecq_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output mecq_pkg::mecq_entry_t head_entry
);
    import mecq_pkg::*;

    mecq_entry_t       slot_reg [Q_DEPTH];
    logic [Q_PW-1:0]   wr_ptr_reg;
    logic [Q_PW-1:0]   rd_ptr_reg;
    logic [Q_PW:0]     count_reg;

    assign full       = (count_reg == (Q_PW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Store incoming transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// File: hw/rtl/mecq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element checker back end
// Area, corner sines over a shared multiplier and step unit, accumulators.
// ----------------------------------------------------------------------------
module mecq_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  mecq_pkg::mecq_entry_t         head_entry,
    output logic                          pop,
    input  logic [mecq_pkg::LIMIT_W-1:0]  zero_area_limit,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mecq_pkg::mecq_result_t        result
);
    import mecq_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_AREA, B_CMUL, B_CSQRT, B_CFIN, B_DONE} bstate_t;

    function automatic logic signed [DIFF_W-1:0] dif(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
        dif = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic signed [MUL_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
        sx = MUL_W'(v);
    endfunction

    function automatic logic signed [MUL_W-1:0] zx(input logic [HALF_W-1:0] v);
        zx = {1'b0, v};
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c < CNT_W'(MAX_ELEMENTS)) ? c + 1'b1 : c;
    endfunction

    bstate_t                  state_reg;
    logic [3:0]               step_reg;
    logic [1:0]               op_reg;
    mecq_point_t [3:0]        pt_reg;
    logic [1:0]               corner_reg;
    logic signed [AREA_W-1:0] area_reg;
    logic signed [CROSS_W-1:0] cross_reg;
    logic [NORM_W-1:0]        na_reg;
    logic [NORM_W-1:0]        nb_reg;
    logic [P_W-1:0]           p_reg;
    logic [SQ_W-1:0]          r_reg;
    logic [SQ_W-1:0]          q_reg;
    logic [U_W-1:0]           u_reg;
    logic [BIT_W-1:0]         bit_reg;
    logic                     degen_reg;
    logic signed [JSUM_W-1:0] jsum_reg;
    logic [2:0]               negs_reg;
    logic [CNT_W-1:0]         tri_total_reg;
    logic [CNT_W-1:0]         quad_total_reg;
    logic [CNT_W-1:0]         neg_tri_reg;
    logic [CNT_W-1:0]         neg_quad_reg;
    logic [CNT_W-1:0]         class_cnt_reg [4];
    logic signed [SUM_W-1:0]  area_sum_reg;
    logic                     zero_seen_reg;
    logic                     result_valid_reg;
    mecq_result_t             result_reg;

    // Edge vectors for area and for the current corner
    logic signed [DIFF_W-1:0] v1x, v1y, v2x, v2y;
    logic signed [DIFF_W-1:0] ax, ay, bx, by;
    logic [CROSS_W-1:0]       mag_full;
    logic [NORM_W-1:0]        mag;
    mecq_point_t              pc, pn, pp;

    always_comb
    begin
        if (op_reg == OP_TRIANGLE)
        begin
            v1x = dif(pt_reg[1].x, pt_reg[0].x);
            v1y = dif(pt_reg[1].y, pt_reg[0].y);
            v2x = dif(pt_reg[2].x, pt_reg[0].x);
            v2y = dif(pt_reg[2].y, pt_reg[0].y);
        end
        else
        begin
            v1x = dif(pt_reg[2].x, pt_reg[0].x);
            v1y = dif(pt_reg[2].y, pt_reg[0].y);
            v2x = dif(pt_reg[3].x, pt_reg[1].x);
            v2y = dif(pt_reg[3].y, pt_reg[1].y);
        end
    end

    assign pc       = pt_reg[corner_reg];
    assign pn       = pt_reg[corner_reg + 2'd1];
    assign pp       = pt_reg[corner_reg - 2'd1];
    assign ax       = dif(pn.x, pc.x);
    assign ay       = dif(pn.y, pc.y);
    assign bx       = dif(pp.x, pc.x);
    assign by       = dif(pp.y, pc.y);
    assign mag_full = cross_reg[CROSS_W-1] ? CROSS_W'(-cross_reg) : CROSS_W'(cross_reg);
    assign mag      = mag_full[NORM_W-1:0];

    // Shared multiplier operand select
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [NORM_W-1:0]        prod_u;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == B_AREA)
        begin
            if (step_reg == 4'd0)
            begin
                mul_a = sx(v1x);
                mul_b = sx(v2y);
            end
            else
            begin
                mul_a = sx(v1y);
                mul_b = sx(v2x);
            end
        end
        else
        begin
            case (step_reg)
                4'd0:    begin mul_a = sx(ax); mul_b = sx(by); end
                4'd1:    begin mul_a = sx(ay); mul_b = sx(bx); end
                4'd2:    begin mul_a = sx(ax); mul_b = sx(ax); end
                4'd3:    begin mul_a = sx(ay); mul_b = sx(ay); end
                4'd4:    begin mul_a = sx(bx); mul_b = sx(bx); end
                4'd5:    begin mul_a = sx(by); mul_b = sx(by); end
                4'd6:    begin mul_a = zx(na_reg[HALF_W-1:0]);
                               mul_b = zx(nb_reg[HALF_W-1:0]); end
                4'd7:    begin mul_a = zx(na_reg[NORM_W-1:HALF_W]);
                               mul_b = zx(nb_reg[HALF_W-1:0]); end
                4'd8:    begin mul_a = zx(na_reg[HALF_W-1:0]);
                               mul_b = zx(nb_reg[NORM_W-1:HALF_W]); end
                4'd9:    begin mul_a = zx(na_reg[NORM_W-1:HALF_W]);
                               mul_b = zx(nb_reg[NORM_W-1:HALF_W]); end
                4'd10:   begin mul_a = zx(mag[HALF_W-1:0]); mul_b = zx(mag[HALF_W-1:0]); end
                4'd11:   begin mul_a = zx(mag[HALF_W-1:0]);
                               mul_b = zx(mag[NORM_W-1:HALF_W]); end
                4'd12:   begin mul_a = zx(mag[NORM_W-1:HALF_W]);
                               mul_b = zx(mag[NORM_W-1:HALF_W]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod   = mul_a * mul_b;
    assign prod_u = prod[NORM_W-1:0];

    // Root digit trial: (u * P) << (b + 1) + P << 2b against remainder
    logic [SQ_W-1:0] trial;
    logic            trial_ok;
    assign trial    = (q_reg << ({1'b0, bit_reg} + 5'd1))
                    + (SQ_W'(p_reg) << {bit_reg, 1'b0});
    assign trial_ok = (trial <= r_reg);

    // Corner sine, floored
    logic signed [J_W-1:0] j_val;
    always_comb
    begin
        if (degen_reg)
        begin
            j_val = '0;
        end
        else if (!cross_reg[CROSS_W-1])
        begin
            j_val = J_W'(u_reg);
        end
        else
        begin
            j_val = -(J_W'(u_reg) + J_W'(r_reg != '0));
        end
    end

    // Result values for the finished item
    logic [AREA_W-1:0]       amag;
    logic                    area_neg;
    logic                    area_zero;
    logic [1:0]              cls;
    logic [1:0]              status;
    logic [1:0]              verdict;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    load_out;
    mecq_result_t            res;

    assign area_neg  = area_reg[AREA_W-1];
    assign amag      = area_neg ? AREA_W'(-area_reg) : AREA_W'(area_reg);
    assign area_zero = (amag <= AREA_W'(zero_area_limit));
    assign status    = area_zero ? ST_ZERO : (area_neg ? ST_NEGATIVE : ST_POSITIVE);
    assign sum_wide  = (SUM_W+1)'(area_sum_reg) + (SUM_W+1)'(area_reg);
    assign load_out  = (state_reg == B_DONE) && (!result_valid_reg || result_ready);
    assign pop       = (state_reg == B_IDLE) && head_valid;

    always_comb
    begin
        if (negs_reg == 3'd4)
        begin
            cls = CL_NEGATIVE;
        end
        else if (jsum_reg <= 0)
        begin
            cls = CL_NEGATIVE_SKEWED;
        end
        else if (negs_reg != 3'd0)
        begin
            cls = CL_POSITIVE_SKEWED;
        end
        else
        begin
            cls = CL_POSITIVE;
        end
    end

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_comb
    begin
        if (zero_seen_reg)
        begin
            verdict = VD_ZERO_AREA;
        end
        else if (((tri_total_reg | quad_total_reg) != '0) &&
                 (neg_tri_reg == tri_total_reg) && (neg_quad_reg == quad_total_reg))
        begin
            verdict = VD_ALL_NEGATIVE;
        end
        else if ((neg_tri_reg != '0) && (neg_quad_reg != '0))
        begin
            verdict = VD_MIXED;
        end
        else
        begin
            verdict = VD_VALID;
        end
    end

    always_comb
    begin
        res             = '0;
        res.area_status = ST_NOT_ELEMENT;
        case (op_reg)
            OP_TRIANGLE:
            begin
                res.area_twice  = area_reg;
                res.area_status = status;
            end
            OP_QUAD:
            begin
                res.area_twice  = area_reg;
                res.area_status = status;
                res.quad_class  = cls;
            end
            OP_FINISH:
            begin
                res.total_area_twice      = area_sum_reg;
                res.negative_triangles    = neg_tri_reg;
                res.negative_quads        = neg_quad_reg;
                res.quads_negative        = class_cnt_reg[0];
                res.quads_negative_skewed = class_cnt_reg[1];
                res.quads_positive_skewed = class_cnt_reg[2];
                res.quads_positive        = class_cnt_reg[3];
                res.verdict               = verdict;
            end
            default:
            begin
                res.area_status = ST_NOT_ELEMENT;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Sequencer, datapath registers, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            step_reg         <= '0;
            op_reg           <= '0;
            pt_reg           <= '0;
            corner_reg       <= '0;
            area_reg         <= '0;
            cross_reg        <= '0;
            na_reg           <= '0;
            nb_reg           <= '0;
            p_reg            <= '0;
            r_reg            <= '0;
            q_reg            <= '0;
            u_reg            <= '0;
            bit_reg          <= '0;
            degen_reg        <= 1'b0;
            jsum_reg         <= '0;
            negs_reg         <= '0;
            tri_total_reg    <= '0;
            quad_total_reg   <= '0;
            neg_tri_reg      <= '0;
            neg_quad_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                class_cnt_reg[i] <= '0;
            end
            area_sum_reg     <= '0;
            zero_seen_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // Drop the output once taken, unless a new one replaces it
            if (result_valid_reg && result_ready && !load_out)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (head_valid)
                    begin
                        op_reg   <= head_entry.operation;
                        pt_reg   <= head_entry.pt;
                        step_reg <= '0;
                        if ((head_entry.operation == OP_TRIANGLE) ||
                            (head_entry.operation == OP_QUAD))
                        begin
                            state_reg <= B_AREA;
                        end
                        else
                        begin
                            state_reg <= B_DONE;
                        end
                    end
                end
                B_AREA:
                begin
                    if (step_reg == 4'd0)
                    begin
                        area_reg <= AREA_W'(prod);
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        area_reg   <= area_reg - AREA_W'(prod);
                        step_reg   <= '0;
                        corner_reg <= '0;
                        jsum_reg   <= '0;
                        negs_reg   <= '0;
                        state_reg  <= (op_reg == OP_QUAD) ? B_CMUL : B_DONE;
                    end
                end
                B_CMUL:
                begin
                    step_reg <= (step_reg >= 4'd12) ? 4'd0 : step_reg + 4'd1;
                    case (step_reg)
                        4'd0:  cross_reg <= CROSS_W'(prod);
                        4'd1:  cross_reg <= cross_reg - CROSS_W'(prod);
                        4'd2:  na_reg <= prod_u;
                        4'd3:  na_reg <= na_reg + prod_u;
                        4'd4:  nb_reg <= prod_u;
                        4'd5:  nb_reg <= nb_reg + prod_u;
                        4'd6:  p_reg <= P_W'(prod_u);
                        4'd7:  p_reg <= p_reg + (P_W'(prod_u) << HALF_W);
                        4'd8:  p_reg <= p_reg + (P_W'(prod_u) << HALF_W);
                        4'd9:  p_reg <= p_reg + (P_W'(prod_u) << (2 * HALF_W));
                        4'd10: r_reg <= SQ_W'(prod_u) << (2 * SINE_FRAC_BITS);
                        4'd11: r_reg <= r_reg
                                      + (SQ_W'(prod_u) << (HALF_W + 1 + 2 * SINE_FRAC_BITS));
                        4'd12:
                        begin
                            r_reg     <= r_reg
                                       + (SQ_W'(prod_u) << (2 * HALF_W + 2 * SINE_FRAC_BITS));
                            q_reg     <= '0;
                            u_reg     <= '0;
                            bit_reg   <= BIT_W'(U_W - 1);
                            degen_reg <= (na_reg == '0) || (nb_reg == '0);
                            state_reg <= B_CSQRT;
                        end
                        default: ;
                    endcase
                end
                B_CSQRT:
                begin
                    // One root bit per cycle
                    if (trial_ok)
                    begin
                        r_reg <= r_reg - trial;
                        q_reg <= q_reg + (SQ_W'(p_reg) << bit_reg);
                        u_reg <= u_reg | (U_W'(1) << bit_reg);
                    end
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        state_reg <= B_CFIN;
                    end
                end
                B_CFIN:
                begin
                    jsum_reg   <= jsum_reg + JSUM_W'(j_val);
                    negs_reg   <= negs_reg + 3'(j_val[J_W-1]);
                    corner_reg <= corner_reg + 2'd1;
                    step_reg   <= '0;
                    state_reg  <= (corner_reg == 2'd3) ? B_DONE : B_CMUL;
                end
                B_DONE:
                begin
                    if (load_out)
                    begin
                        result_reg       <= res;
                        result_valid_reg <= 1'b1;
                        state_reg        <= B_IDLE;
                        case (op_reg)
                            OP_TRIANGLE:
                            begin
                                area_sum_reg  <= sum_sat;
                                zero_seen_reg <= zero_seen_reg | area_zero;
                                tri_total_reg <= sat_inc(tri_total_reg);
                                if (area_neg)
                                begin
                                    neg_tri_reg <= sat_inc(neg_tri_reg);
                                end
                            end
                            OP_QUAD:
                            begin
                                area_sum_reg   <= sum_sat;
                                zero_seen_reg  <= zero_seen_reg | area_zero;
                                quad_total_reg <= sat_inc(quad_total_reg);
                                if (area_neg)
                                begin
                                    neg_quad_reg <= sat_inc(neg_quad_reg);
                                end
                                class_cnt_reg[cls] <= sat_inc(class_cnt_reg[cls]);
                            end
                            OP_FINISH:
                            begin
                                area_sum_reg   <= '0;
                                zero_seen_reg  <= 1'b0;
                                tri_total_reg  <= '0;
                                quad_total_reg <= '0;
                                neg_tri_reg    <= '0;
                                neg_quad_reg   <= '0;
                                for (int i = 0; i < 4; i++)
                                begin
                                    class_cnt_reg[i] <= '0;
                                end
                            end
                            default:
                            begin
                                zero_seen_reg <= zero_seen_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mesh_element_quality_checker_unit.sv
`timescale 1ns / 1ps
// Throughput is set by the back end's shared multiplier and one-bit-per-cycle root
//   unit and, for triangles, by the front's corner gather; the queue lets the front
//   take a new item while the back end is still working on an earlier one.
// Front gathers corners through the node store's registered read port.
// Reset clears counters, area total, zero-area flag and the limit register;
//   the node store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// Mesh element quality checker
// Top level: front end, queue, back end and the configuration register port.
// ----------------------------------------------------------------------------
module mesh_element_quality_checker_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  mecq_pkg::mecq_item_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output mecq_pkg::mecq_result_t result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import mecq_pkg::*;

    logic                 push;
    mecq_entry_t          push_entry;
    logic                 q_full;
    logic                 pop;
    logic                 head_valid;
    mecq_entry_t          head_entry;
    logic [LIMIT_W-1:0]   limit_reg;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ZERO_AREA_LIMIT) ? 32'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_ZERO_AREA_LIMIT))
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    mecq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    mecq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    mecq_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .pop             (pop),
        .zero_area_limit (limit_reg),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result)
    );

endmodule
